// ----- hw/rtl/double_to_fixed_decimal_text_top_assert.svh -----
// Assertion macros shared by the formatter's RTL.
`ifndef DOUBLE_TO_FIXED_DECIMAL_TEXT_TOP_ASSERT_SVH
`define DOUBLE_TO_FIXED_DECIMAL_TEXT_TOP_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define DTF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtf assertion failed");

// Next-cycle implication under the active-low reset.
`define DTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtf assertion failed");

`endif

// ----- hw/rtl/dtf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// Types, constants and tables shared by the decimal text formatter.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int MAX_PRECISION = 15;
    localparam int MAX_WIDTH     = 64;
    localparam int INT_W         = 32;
    localparam int FRAC_W        = 64;
    localparam int FX_W          = INT_W + FRAC_W;
    localparam int BCD_DIGITS    = 10;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int CNT_W         = 7;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef enum logic [2:0] {
        SEL_SPACE,
        SEL_SPECIAL,
        SEL_SIGN,
        SEL_INT,
        SEL_POINT,
        SEL_FRAC
    } sel_t;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_NAN,
        SPEC_INF,
        SPEC_OVF
    } spec_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic round;
        logic conv_load;
        logic conv_step;
        logic setup;
        logic emit;
        sel_t sel;
    } dtf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic special;
        logic neg;
        logic has_frac;
        logic left;
        logic pad_zero;
        logic pad_last;
        logic spec_last;
        logic int_last;
        logic frac_last;
        logic rem_last;
        logic conv_last;
    } dtf_status_t;

    // Half a unit of the last digit: floor(2^63 / 10^p) in 64 fraction bits.
    function automatic logic [FRAC_W-1:0] round_const(input logic [3:0] p);
        logic [FRAC_W-1:0] r;
        case (p)
            4'd0:    r = 64'd9223372036854775808;
            4'd1:    r = 64'd922337203685477580;
            4'd2:    r = 64'd92233720368547758;
            4'd3:    r = 64'd9223372036854775;
            4'd4:    r = 64'd922337203685477;
            4'd5:    r = 64'd92233720368547;
            4'd6:    r = 64'd9223372036854;
            4'd7:    r = 64'd922337203685;
            4'd8:    r = 64'd92233720368;
            4'd9:    r = 64'd9223372036;
            4'd10:   r = 64'd922337203;
            4'd11:   r = 64'd92233720;
            4'd12:   r = 64'd9223372;
            4'd13:   r = 64'd922337;
            4'd14:   r = 64'd92233;
            4'd15:   r = 64'd9223;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] spec_char(input spec_t k, input logic [1:0] idx);
        logic [6:0] c;
        c = CH_SPACE;
        case (k)
            SPEC_NAN: c = (idx == 2'd1) ? 7'h61 : 7'h6E;
            SPEC_INF: c = (idx == 2'd0) ? 7'h69 : ((idx == 2'd1) ? 7'h6E : 7'h66);
            SPEC_OVF: c = (idx == 2'd0) ? 7'h6F : ((idx == 2'd1) ? 7'h76 : 7'h66);
            default:  c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dtf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_ctrl
// Sequencer: decode, round, integer conversion, then one character per slot.
// ----------------------------------------------------------------------------
module dtf_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  dtf_pkg::dtf_status_t status,
    output dtf_pkg::dtf_cmd_t    cmd
);
    import dtf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROUND,
        ST_CONV_LOAD,
        ST_CONV,
        ST_SETUP,
        ST_START,
        ST_PRE_PAD,
        ST_SPECIAL,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC,
        ST_POST_PAD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   emit_state;
    state_t text_first;

    assign s_ready = s_ready_reg;

    always_comb begin
        text_first = status.special ? ST_SPECIAL : (status.neg ? ST_SIGN : ST_INT);
        emit_state = 1'b0;
        cmd = '0;
        cmd.sel = SEL_SPACE;
        case (state_reg)
            ST_SPECIAL: cmd.sel = SEL_SPECIAL;
            ST_SIGN:    cmd.sel = SEL_SIGN;
            ST_INT:     cmd.sel = SEL_INT;
            ST_POINT:   cmd.sel = SEL_POINT;
            ST_FRAC:    cmd.sel = SEL_FRAC;
            default:    cmd.sel = SEL_SPACE;
        endcase
        case (state_reg)
            ST_PRE_PAD, ST_SPECIAL, ST_SIGN, ST_INT, ST_POINT, ST_FRAC,
            ST_POST_PAD: emit_state = 1'b1;
            default:     emit_state = 1'b0;
        endcase
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.decode    = (state_reg == ST_DECODE);
        cmd.round     = (state_reg == ST_ROUND);
        cmd.conv_load = (state_reg == ST_CONV_LOAD);
        cmd.conv_step = (state_reg == ST_CONV);
        cmd.setup     = (state_reg == ST_SETUP);
        cmd.emit      = emit_state && status.out_free;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_DECODE;
            ST_DECODE:    state_next = ST_ROUND;
            ST_ROUND:     state_next = ST_CONV_LOAD;
            ST_CONV_LOAD: state_next = status.special ? ST_SETUP : ST_CONV;
            ST_CONV:      if (status.conv_last) state_next = ST_SETUP;
            ST_SETUP:     state_next = ST_START;
            ST_START: begin
                state_next = (!status.left && !status.pad_zero) ? ST_PRE_PAD : text_first;
            end
            ST_PRE_PAD:   if (status.pad_last) state_next = text_first;
            ST_SPECIAL:   if (status.spec_last) state_next = ST_POST_PAD;
            ST_SIGN:      state_next = ST_INT;
            ST_INT: begin
                if (status.int_last) begin
                    state_next = status.has_frac ? ST_POINT : ST_POST_PAD;
                end
            end
            ST_POINT:     state_next = ST_FRAC;
            ST_FRAC:      if (status.frac_last) state_next = ST_POST_PAD;
            ST_POST_PAD:  state_next = ST_POST_PAD;
            default:      state_next = ST_IDLE;
        endcase
        // Emit states only move when a character is handed over; the final
        // character of the text always returns to idle.
        if (emit_state) begin
            if (!status.out_free) begin
                state_next = state_reg;
            end else if (status.rem_last) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dtf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_dp
// Datapath: fixed-point decode, rounding, BCD conversion and character output.
// ----------------------------------------------------------------------------
module dtf_dp (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [63:0]          s_value_bits,
    input  wire  [7:0]           field_width,
    input  wire  [3:0]           fraction_digits,
    input  dtf_pkg::dtf_cmd_t    cmd,
    output dtf_pkg::dtf_status_t status,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [6:0]           m_char_code,
    output logic                 m_last_char
);
    import dtf_pkg::*;

    localparam logic [FX_W-1:0] OVF_LIMIT = {32'd4294967040, {FRAC_W{1'b0}}};

    logic [63:0]        value_reg;
    logic [FX_W-1:0]    fx_reg;
    logic               neg_reg;
    spec_t              spec_reg;
    logic [3:0]         prec_reg;
    logic               left_reg;
    logic [INT_W-1:0]   bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [4:0]         conv_cnt_reg;
    logic [CNT_W-1:0]   pad_cnt_reg;
    logic [3:0]         int_cnt_reg;
    logic [3:0]         frac_cnt_reg;
    logic [1:0]         spec_cnt_reg;
    logic [CNT_W-1:0]   rem_cnt_reg;
    logic               m_valid_reg;
    logic [6:0]         char_reg;
    logic               last_reg;

    logic [10:0]        expo;
    logic [51:0]        man;
    logic [FX_W-1:0]    m_ext;
    logic [10:0]        lsh;
    logic [10:0]        rsh;
    logic [FX_W-1:0]    fx_decoded;
    spec_t              spec_decoded;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         nint;
    logic [CNT_W-1:0]   text_len;
    logic [7:0]         width_mag;
    logic [CNT_W-1:0]   width_sat;
    logic [CNT_W-1:0]   total;
    logic [FRAC_W+3:0]  frac_x10;
    logic [3:0]         frac_digit;
    logic [3:0]         int_digit;
    logic [6:0]         char_next;
    logic [3:0]         prec_sat;

    // Decode of the double into 32 integer and 64 fraction bits; fraction bits below 2^-64 are dropped.
    always_comb begin
        expo  = value_reg[62:52];
        man   = value_reg[51:0];
        m_ext = {{(FX_W-53){1'b0}}, (expo != 11'd0), man};
        lsh   = expo - 11'd1011;
        rsh   = 11'd1011 - expo;
        if (expo >= 11'd1011) begin
            fx_decoded = m_ext << lsh[5:0];
        end else if (rsh < 11'd64) begin
            fx_decoded = m_ext >> rsh[5:0];
        end else begin
            fx_decoded = '0;
        end
        if (expo == 11'h7FF) begin
            spec_decoded = (man != 52'd0) ? SPEC_NAN : SPEC_INF;
        end else if (expo >= 11'd1055) begin
            spec_decoded = SPEC_OVF;
        end else begin
            spec_decoded = SPEC_NONE;
        end
        prec_sat = (32'(fraction_digits) > 32'(MAX_PRECISION)) ?
                   4'(MAX_PRECISION) : fraction_digits;
    end

    // One double-dabble step: add three to every digit of five or more.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        nint = 4'd1;
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) nint = 4'(i + 1);
        end
        if (spec_reg != SPEC_NONE) begin
            text_len = 7'd3;
        end else begin
            text_len = 7'(neg_reg) + 7'(nint) +
                       ((prec_reg != 4'd0) ? (7'(prec_reg) + 7'd1) : 7'd0);
        end
        width_mag = field_width[7] ? (~field_width + 8'd1) : field_width;
        width_sat = (width_mag > 8'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_mag[6:0];
        total     = (width_sat > text_len) ? width_sat : text_len;
    end

    always_comb begin
        frac_x10   = ({4'd0, fx_reg[FRAC_W-1:0]} << 3) + ({4'd0, fx_reg[FRAC_W-1:0]} << 1);
        frac_digit = (frac_x10[FRAC_W+3:FRAC_W] > 4'd9) ? 4'd9 : frac_x10[FRAC_W+3:FRAC_W];
        int_digit  = 4'd0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (int_cnt_reg == 4'(i + 1)) int_digit = bcd_reg[4*i +: 4];
        end
        case (cmd.sel)
            SEL_SPACE:   char_next = CH_SPACE;
            SEL_SPECIAL: char_next = spec_char(spec_reg, 2'd3 - spec_cnt_reg);
            SEL_SIGN:    char_next = CH_MINUS;
            SEL_INT:     char_next = CH_ZERO + 7'(int_digit);
            SEL_POINT:   char_next = CH_POINT;
            SEL_FRAC:    char_next = CH_ZERO + 7'(frac_digit);
            default:     char_next = CH_SPACE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) value_reg <= s_value_bits;

        if (cmd.decode) begin
            fx_reg   <= fx_decoded;
            neg_reg  <= value_reg[63] && ((expo != 11'd0) || (man != 52'd0));
            spec_reg <= spec_decoded;
            prec_reg <= prec_sat;
            left_reg <= field_width[7];
        end else if (cmd.round) begin
            if ((spec_reg == SPEC_NONE) && (fx_reg > OVF_LIMIT)) spec_reg <= SPEC_OVF;
            fx_reg <= fx_reg + {{INT_W{1'b0}}, round_const(prec_reg)};
        end else if (cmd.emit && (cmd.sel == SEL_FRAC)) begin
            fx_reg[FRAC_W-1:0] <= frac_x10[FRAC_W-1:0];
        end

        if (cmd.conv_load) begin
            bin_reg      <= fx_reg[FX_W-1:FRAC_W];
            bcd_reg      <= '0;
            conv_cnt_reg <= '0;
        end else if (cmd.conv_step) begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            conv_cnt_reg       <= conv_cnt_reg + 5'd1;
        end

        if (cmd.setup) begin
            pad_cnt_reg  <= total - text_len;
            rem_cnt_reg  <= total;
            int_cnt_reg  <= nint;
            frac_cnt_reg <= prec_reg;
            spec_cnt_reg <= 2'd3;
        end else if (cmd.emit) begin
            rem_cnt_reg <= rem_cnt_reg - 7'd1;
            case (cmd.sel)
                SEL_SPACE:   pad_cnt_reg  <= pad_cnt_reg - 7'd1;
                SEL_SPECIAL: spec_cnt_reg <= spec_cnt_reg - 2'd1;
                SEL_INT:     int_cnt_reg  <= int_cnt_reg - 4'd1;
                SEL_FRAC:    frac_cnt_reg <= frac_cnt_reg - 4'd1;
                default:     ;
            endcase
        end

        if (cmd.emit) begin
            char_reg <= char_next;
            last_reg <= (rem_cnt_reg == 7'd1);
        end

        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;

    always_comb begin
        status.out_free  = !m_valid_reg || m_ready;
        status.special   = (spec_reg != SPEC_NONE);
        status.neg       = neg_reg;
        status.has_frac  = (prec_reg != 4'd0);
        status.left      = left_reg;
        status.pad_zero  = (pad_cnt_reg == 7'd0);
        status.pad_last  = (pad_cnt_reg == 7'd1);
        status.spec_last = (spec_cnt_reg == 2'd1);
        status.int_last  = (int_cnt_reg == 4'd1);
        status.frac_last = (frac_cnt_reg == 4'd1);
        status.rem_last  = (rem_cnt_reg == 7'd1);
        status.conv_last = (conv_cnt_reg == 5'(INT_W - 1));
    end

endmodule
`default_nettype wire

// ----- hw/rtl/double_to_fixed_decimal_text_top.sv -----
// A number is taken in, decoded and rounded, and its integer part is converted
// to decimal by a shift-and-add-three loop over its 32 integer bits (skipped
// for nan, inf and ovf); then one character leaves per cycle while the output
// is taken. The next number is accepted once the last character has been
// placed in the output register.
`default_nettype none
`include "double_to_fixed_decimal_text_top_assert.svh"
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text_top
// Formats a double as space-padded fixed-point decimal text, one character
// per output request, with a register port for width and precision.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [63:0] s_value_bits,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [6:0]  m_char_code,
    output logic        m_last_char,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dtf_pkg::*;

    typedef enum logic {
        REG_FIELD_WIDTH,
        REG_FRACTION_DIGITS
    } reg_idx_t;

    logic [7:0]  field_width_reg;
    logic [3:0]  fraction_digits_reg;
    reg_idx_t    reg_idx;
    dtf_cmd_t    cmd;
    dtf_status_t status;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg     <= 8'd0;
            fraction_digits_reg <= 4'd2;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_FIELD_WIDTH:     field_width_reg     <= pwdata[7:0];
                REG_FRACTION_DIGITS: fraction_digits_reg <= pwdata[3:0];
                default:             field_width_reg     <= field_width_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FIELD_WIDTH:     prdata = {{24{field_width_reg[7]}}, field_width_reg};
            REG_FRACTION_DIGITS: prdata = {28'd0, fraction_digits_reg};
            default:             prdata = '0;
        endcase
    end

    dtf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dtf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_value_bits    (s_value_bits),
        .field_width     (field_width_reg),
        .fraction_digits (fraction_digits_reg),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_last_char     (m_last_char)
    );

    `DTF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DTF_ASSERT_IMPLY(a_no_emit_when_idle, aclk, aresetn, cmd.emit, !s_ready)
    `DTF_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, cmd.emit && status.rem_last, s_ready)

endmodule
`default_nettype wire

// ----- tb/double_to_fixed_decimal_text_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text_top_tb
// Sends double bit patterns through the formatter under several width and
// precision settings, and checks every emitted character and its last flag
// against a fixed-point prediction of the padded decimal text.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text_top_tb;
    import dtf_pkg::*;

    localparam logic [2:0] ADDR_FIELD_WIDTH     = 3'd0;
    localparam logic [2:0] ADDR_FRACTION_DIGITS = 3'd4;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_value_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_char_code;
    logic        m_last_char;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [63:0]  pending_values[$];
    text_char_t   expected_text[$];
    logic signed [7:0] cfg_width = 8'sd0;
    logic [3:0]   cfg_digits = 4'd2;
    int           error_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_left = 0;
    bit           hold_request = 1'b0;
    logic         s_ready_taken = 1'b0;

    double_to_fixed_decimal_text_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_value_bits(s_value_bits),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_char_code(m_char_code), .m_last_char(m_last_char),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Builds the expected text of one number and queues its characters.
    task automatic queue_decimal_text(input logic [63:0] bits);
        logic [6:0]   text[0:127];
        logic [6:0]   digs[0:11];
        int           len, nd, e, sh, w, total, pad, k;
        logic [10:0]  expo;
        logic [51:0]  man;
        logic [159:0] fx;
        logic [95:0]  acc;
        logic [63:0]  half, frac;
        logic [31:0]  ip;
        logic [67:0]  t;
        bit           left;
        text_char_t   c;
        len = 0;
        expo = bits[62:52];
        man = bits[51:0];
        if (expo == 11'h7FF) begin
            if (man != 0) begin
                text[0] = 7'h6E; text[1] = 7'h61; text[2] = 7'h6E;
            end else begin
                text[0] = 7'h69; text[1] = 7'h6E; text[2] = 7'h66;
            end
            len = 3;
        end else begin
            fx = '0;
            fx[52:0] = (expo == 0) ? {1'b0, man} : {1'b1, man};
            e = (expo == 0) ? -1074 : int'(expo) - 1075;
            sh = e + 128;
            if (sh >= 0) fx = fx << sh;
            else fx = fx >> (-sh);
            if (expo >= 11'd1055 || fx[159:128] > 32'd4294967040 ||
                (fx[159:128] == 32'd4294967040 && fx[127:0] != 0)) begin
                text[0] = 7'h6F; text[1] = 7'h76; text[2] = 7'h66;
                len = 3;
            end else begin
                if (bits[63] && bits[62:0] != 0) begin
                    text[len] = CH_MINUS;
                    len++;
                end
                half = 64'h8000_0000_0000_0000;
                for (k = 0; k < cfg_digits; k++) half = half / 10;
                acc = fx[159:64] + {32'd0, half};
                ip = acc[95:64];
                frac = acc[63:0];
                nd = 0;
                do begin
                    digs[nd] = CH_ZERO + 7'(ip % 10);
                    nd++;
                    ip = ip / 10;
                end while (ip != 0);
                while (nd > 0) begin
                    nd--;
                    text[len] = digs[nd];
                    len++;
                end
                if (cfg_digits > 0) begin
                    text[len] = CH_POINT;
                    len++;
                end
                for (k = 0; k < cfg_digits; k++) begin
                    t = {4'd0, frac} * 68'd10;
                    frac = t[63:0];
                    text[len] = CH_ZERO + ((t[67:64] > 9) ? 7'd9 : 7'(t[67:64]));
                    len++;
                end
            end
        end
        w = cfg_width;
        left = w < 0;
        if (left) w = -w;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        total = (w > len) ? w : len;
        pad = total - len;
        for (k = 0; k < total; k++) begin
            if (left) c.code = (k < len) ? text[k] : CH_SPACE;
            else c.code = (k < pad) ? CH_SPACE : text[k - pad];
            c.last = (k == total - 1);
            expected_text.push_back(c);
        end
    endtask

    // Request side: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        logic        nv;
        logic [63:0] nd;
        nv = s_valid;
        nd = s_value_bits;
        if (aresetn && (!s_valid || s_ready_taken)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_values.size() > 0) begin
                nv = 1'b1;
                nd = pending_values.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
        s_valid <= nv;
        s_value_bits <= nd;
    end

    always @(posedge aclk) begin
        s_ready_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) queue_decimal_text(s_value_bits);
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character %h", m_char_code);
                error_count++;
            end else begin
                text_char_t c;
                c = expected_text.pop_front();
                if (m_char_code !== c.code) begin
                    $error("char_code: expected %h, actual %h", c.code, m_char_code);
                    error_count++;
                end
                if (m_last_char !== c.last) begin
                    $error("last_char: expected %b, actual %b", c.last, m_last_char);
                    error_count++;
                end
            end
        end
    end

    // Result side: random stalls and one long hold-off.
    always @(negedge aclk) begin
        logic r;
        if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else if (($urandom_range(0, 255) / 64) == 0) begin
            r = 1'b1;
        end else begin
            r = ($urandom_range(0, 3) != 0);
        end
        m_ready <= r;
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_idle;
        while (pending_values.size() > 0 || s_valid || expected_text.size() > 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [63:0] random_double;
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1, 2: v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 31));
            3: v[62:52] = 11'($urandom_range(1023 + 28, 1023 + 32));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic signed [7:0] widths[6] = '{8'sd0, 8'sd64, -8'sd64, 8'sd127, -8'sd128, 8'sd9};
        logic [3:0] precs[6] = '{4'd2, 4'd0, 4'd15, 4'd6, 4'd1, 4'd3};
        logic [63:0] directed[$] = '{
            64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
            64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0001,
            64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h41EF_FFFF_FFE0_0000, 64'hC1EF_FFFF_FFE0_0001,
            64'h41F0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
            64'h3FF0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
            64'h3F74_7AE1_47AE_147B, 64'h4023_FD70_A3D7_0A3D,
            64'h405E_DD2F_1A9F_BE77, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h3FEF_FFFF_FFFF_FFFF, 64'h41DF_FFFF_FFC0_0000,
            64'hBCB0_0000_0000_0000, 64'h4059_0000_0000_0000};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            write_register(ADDR_FIELD_WIDTH, {$urandom} & 32'hFFFF_FF00
                           | {24'd0, widths[ph]});
            write_register(ADDR_FRACTION_DIGITS, {$urandom} & 32'hFFFF_FFF0 | precs[ph]);
            cfg_width = widths[ph];
            cfg_digits = precs[ph];
            if (ph == 0) foreach (directed[i]) pending_values.push_back(directed[i]);
            for (int i = 0; i < 32; i++) pending_values.push_back(random_double());
            if (ph == 2) hold_request = 1'b1;
            wait_idle();
        end
        repeat (50) @(negedge aclk);
        if (error_count == 0) $display("double_to_fixed_decimal_text_top_tb: clean");
        else $display("double_to_fixed_decimal_text_top_tb: errors");
        $finish;
    end

    initial begin
        #1000000;
        $display("double_to_fixed_decimal_text_top_tb: errors");
        $finish;
    end
endmodule
